>>> rtl/sc2k_pkg.sv
package sc2k_pkg;

  localparam int EK_DEPTH_DEF = 64;
  localparam int KE_T_SKIP    = 36;
  localparam int IK_COUNT     = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_REGS     = 4;

  localparam logic [31:0] MASK_55 = 32'h55555555;
  localparam logic [31:0] MASK_33 = 32'h33333333;

  typedef logic [3:0][31:0] blk_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_INT,
    ST_KEY_EXP,
    ST_XOR_A,
    ST_SUB,
    ST_XOR_B,
    ST_ROUND,
    ST_DONE
  } state_t;

  localparam logic [5:0] SBOX6 [64] = '{
    6'd47, 6'd59, 6'd25, 6'd42, 6'd15, 6'd23, 6'd28, 6'd39,
    6'd26, 6'd38, 6'd36, 6'd19, 6'd60, 6'd24, 6'd29, 6'd56,
    6'd37, 6'd63, 6'd20, 6'd61, 6'd55, 6'd2,  6'd30, 6'd44,
    6'd9,  6'd10, 6'd6,  6'd22, 6'd53, 6'd48, 6'd51, 6'd11,
    6'd62, 6'd52, 6'd35, 6'd18, 6'd14, 6'd46, 6'd0,  6'd54,
    6'd17, 6'd40, 6'd27, 6'd4,  6'd31, 6'd8,  6'd5,  6'd12,
    6'd3,  6'd16, 6'd41, 6'd34, 6'd33, 6'd7,  6'd45, 6'd49,
    6'd50, 6'd58, 6'd1,  6'd21, 6'd43, 6'd57, 6'd32, 6'd13
  };

  localparam logic [4:0] SBOX5 [32] = '{
    5'd20, 5'd26, 5'd7,  5'd31, 5'd19, 5'd12, 5'd10, 5'd15,
    5'd22, 5'd30, 5'd13, 5'd14, 5'd4,  5'd24, 5'd9,  5'd18,
    5'd27, 5'd11, 5'd1,  5'd21, 5'd6,  5'd16, 5'd2,  5'd28,
    5'd23, 5'd5,  5'd8,  5'd3,  5'd0,  5'd17, 5'd29, 5'd25
  };

  localparam logic [3:0] SBOX4 [16] = '{
    4'd2, 4'd5, 4'd10, 4'd12, 4'd7, 4'd15, 4'd1, 4'd11,
    4'd13, 4'd6, 4'd0, 4'd9, 4'd4, 4'd8, 4'd3, 4'd14
  };

  localparam logic [3:0] SBOX4_INV [16] = '{
    4'd10, 4'd6, 4'd0, 4'd14, 4'd12, 4'd1, 4'd9, 4'd4,
    4'd13, 4'd11, 4'd2, 4'd7, 4'd3, 4'd8, 4'd15, 4'd5
  };

  // row k joins the sum when bit 31-k of the input is set
  localparam logic [31:0] MIX_ROWS [32] = '{
    32'hd0c19225, 32'ha5a2240a, 32'h1b84d250, 32'hb728a4a1,
    32'h6a704902, 32'h85dddbe6, 32'h766ff4a4, 32'hecdfe128,
    32'hafd13e94, 32'hdf837d09, 32'hbb27fa52, 32'h695059ac,
    32'h52a1bb58, 32'hcc322f1d, 32'h1844565b, 32'hb4a8acf6,
    32'h34235438, 32'h6847a851, 32'he48c0cbb, 32'hcd181136,
    32'h9a112a0c, 32'h43ec6d0e, 32'h87d8d27d, 32'h487dc995,
    32'h90fb9b4b, 32'ha1f63697, 32'hfc513ed9, 32'h78a37d93,
    32'h8d16c5df, 32'h9e0c8bbe, 32'h3c381f7c, 32'he9fb0779
  };

  localparam logic [1:0] GROUP_ORDER [12][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd3, 2'd1}, '{2'd1, 2'd3, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1, 2'd3}, '{2'd3, 2'd1, 2'd0, 2'd2},
    '{2'd0, 2'd3, 2'd1, 2'd2}, '{2'd1, 2'd2, 2'd0, 2'd3},
    '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd3, 2'd0, 2'd2, 2'd1}
  };

  localparam logic [1:0] WORD_PICK [9][4] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd1, 2'd1},
    '{2'd2, 2'd2, 2'd2, 2'd2}, '{2'd0, 2'd1, 2'd0, 2'd1},
    '{2'd1, 2'd2, 2'd1, 2'd2}, '{2'd2, 2'd0, 2'd2, 2'd0},
    '{2'd0, 2'd2, 2'd0, 2'd2}, '{2'd1, 2'd0, 2'd1, 2'd0},
    '{2'd2, 2'd1, 2'd2, 2'd1}
  };

  function automatic logic [31:0] sub_word(input logic [31:0] a);
    return {SBOX6[a[31:26]], SBOX5[a[25:21]], SBOX5[a[20:16]],
            SBOX5[a[15:11]], SBOX5[a[10:6]], SBOX6[a[5:0]]};
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] a);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 32; k++) begin
      if (a[31-k]) r = r ^ MIX_ROWS[k];
    end
    return r;
  endfunction

  function automatic logic [31:0] sm(input logic [31:0] a);
    return mix_word(sub_word(a));
  endfunction

  // bit i of the four words forms one nibble, word 0 in the top bit
  function automatic blk_t bitslice(input blk_t v, input logic dec);
    blk_t o;
    logic [3:0] nib;
    logic [3:0] sub;
    o = '0;
    for (int i = 0; i < 32; i++) begin
      nib = {v[0][i], v[1][i], v[2][i], v[3][i]};
      sub = dec ? SBOX4_INV[nib] : SBOX4[nib];
      o[0][i] = sub[3];
      o[1][i] = sub[2];
      o[2][i] = sub[1];
      o[3][i] = sub[0];
    end
    return o;
  endfunction

  function automatic logic [3:0] ik_addr(input logic [3:0] t, input logic [3:0] s,
                                         input logic [1:0] c);
    logic [3:0] g;
    g = {2'b00, GROUP_ORDER[t][c]};
    return (g << 1) + g + {2'b00, WORD_PICK[s][c]};
  endfunction

endpackage

>>> rtl/sc2k_ifs.sv
interface sc2k_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;
  modport source (output valid, kind, word_a, word_b, word_c, word_d, input ready);
  modport sink   (input valid, kind, word_a, word_b, word_c, word_d, output ready);
endinterface

interface sc2k_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_word_a;
  logic [31:0] out_word_b;
  logic [31:0] out_word_c;
  logic [31:0] out_word_d;
  modport source (output valid, out_word_a, out_word_b, out_word_c, out_word_d,
                  input ready);
  modport sink   (input valid, out_word_a, out_word_b, out_word_c, out_word_d,
                  output ready);
endinterface

interface sc2k_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/sc2000_block_cipher.sv
// SC2000 block cipher, 256-bit key in four 64-bit registers (index 0..3, low word first).
// A request on din carries one 128-bit block and kind (0 encrypt, 1 decrypt); one result
// block follows on dout. All work runs through one shared S/M unit and the read and write
// ports of the expanded key memory under a small sequencer, one item at a time.
// A block runs through 7 rounds: each round does two 4-word key additions (one key word
// a cycle through the registered memory port) and a bit-slice substitution, 6 of them
// add a Feistel pair through the S/M unit, and a final step loads the result. The first
// block after reset or after a key write first derives the key: 12 intermediate words,
// then EK_DEPTH expanded words.
// din is ready only while idle; a finished result waits in the output register.
module sc2000_block_cipher
  import sc2k_pkg::*;
#(
  parameter int EK_DEPTH = EK_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  sc2k_in_if.sink        din,
  sc2k_out_if.source     dout,
  sc2k_cfg_if.sink       cfg
);

  localparam int AW = $clog2(EK_DEPTH);

  state_t        state;
  state_t        state_next;
  logic [2:0]    cnt;
  logic [2:0]    cnt_next;
  logic          cnt_wrap;
  logic [2:0]    rnd;
  logic          dec;
  logic          key_ready;
  logic          out_valid;
  logic          out_load;

  logic [63:0]   key_pair [CFG_REGS];
  logic [31:0]   ik [IK_COUNT];
  logic [31:0]   ek_mem [EK_DEPTH];
  logic [31:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic [5:0]    rd_base;

  logic [1:0]    ki_i;
  logic [1:0]    ki_j;
  logic [3:0]    ki_idx;
  logic          ki_last;
  logic [AW-1:0] n;
  logic [3:0]    et;
  logic [3:0]    es;
  logic [4:0]    et_sum;
  logic [3:0]    pick_addr;
  logic [31:0]   pk [4];
  logic [31:0]   ex_x;
  logic [31:0]   ex_z;
  logic [31:0]   ex_z0;

  blk_t          v;
  logic [31:0]   acc_x;
  logic [31:0]   acc_y;
  logic [31:0]   tmp;
  logic [31:0]   mask;
  logic [31:0]   sm_in;
  logic [31:0]   sm_out;
  logic [31:0]   sm_mul;
  blk_t          res;

  // hold the key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CFG_REGS; k++) key_pair[k] <= '0;
    end else if (cfg.valid && cfg.ready && (cfg.index < CFG_IDX_W'(CFG_REGS))) begin
      key_pair[cfg.index[1:0]] <= cfg.data;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (din.valid) state_next = key_ready ? ST_XOR_A : ST_KEY_INT;
      ST_KEY_INT: if (cnt == 3'd3 && ki_last) state_next = ST_KEY_EXP;
      ST_KEY_EXP: if (cnt == 3'd4 && n == AW'(EK_DEPTH - 1)) state_next = ST_XOR_A;
      ST_XOR_A:   if (cnt == 3'd4) state_next = ST_SUB;
      ST_SUB:     state_next = ST_XOR_B;
      ST_XOR_B:   if (cnt == 3'd4) state_next = (rnd == 3'd6) ? ST_DONE : ST_ROUND;
      ST_ROUND:   if (cnt == 3'd3) state_next = ST_XOR_A;
      ST_DONE:    if (!out_valid || dout.ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    din.ready = (state == ST_IDLE);
    cfg.ready = 1'b1;
    out_load  = (state == ST_DONE) && (!out_valid || dout.ready);
    cnt_wrap  = (state == ST_KEY_INT && cnt == 3'd3) || (state == ST_KEY_EXP && cnt == 3'd4);
  end

  always_comb begin
    if (state_next != state || cnt_wrap || state == ST_IDLE || state == ST_DONE) begin
      cnt_next = '0;
    end else begin
      cnt_next = cnt + 3'd1;
    end
  end

  assign ki_last = (ki_j == 2'd3) && (ki_i == 2'd2);
  assign ki_idx  = (4'(ki_j) << 1) + 4'(ki_j) + 4'(ki_i);

  // advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rnd       <= '0;
      key_ready <= 1'b0;
      out_valid <= 1'b0;
      ki_i      <= '0;
      ki_j      <= '0;
      n         <= '0;
      et        <= '0;
      es        <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == ST_IDLE) begin
        rnd  <= '0;
        ki_i <= '0;
        ki_j <= '0;
        n    <= '0;
        et   <= '0;
        es   <= '0;
      end
      if (state == ST_KEY_INT && cnt == 3'd3) begin
        if (ki_i == 2'd2) begin
          ki_i <= '0;
          ki_j <= ki_j + 2'd1;
        end else begin
          ki_i <= ki_i + 2'd1;
        end
      end
      if (state == ST_KEY_EXP && cnt == 3'd4) begin
        n  <= n + AW'(1);
        es <= (es == 4'd8) ? 4'd0 : es + 4'd1;
        et <= (et_sum >= 5'(IK_COUNT)) ? 4'(et_sum - 5'(IK_COUNT)) : et_sum[3:0];
        if (n == AW'(EK_DEPTH - 1)) key_ready <= 1'b1;
      end
      if (state == ST_ROUND && cnt == 3'd3) rnd <= rnd + 3'd1;
      if (cfg.valid && cfg.ready && (cfg.index < CFG_IDX_W'(CFG_REGS))) key_ready <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // group index skips one extra step where the expanded index reaches the skip point
  assign et_sum = 5'(et) + ((n == AW'(KE_T_SKIP - 1)) ? 5'd2 : 5'd1);

  // feed the shared S/M unit
  always_comb begin
    sm_in = v[3];
    case (state)
      ST_KEY_INT: begin
        case (cnt[1:0])
          2'd0:    sm_in = key_pair[ki_j][31:0];
          2'd1:    sm_in = key_pair[ki_j][63:32];
          2'd2:    sm_in = {28'd0, ki_i, ki_j};
          default: sm_in = acc_x ^ acc_y;
        endcase
      end
      ST_ROUND: begin
        case (cnt[1:0])
          2'd0:    sm_in = v[2];
          2'd1:    sm_in = v[3];
          2'd2:    sm_in = v[0];
          default: sm_in = v[1];
        endcase
      end
      default: sm_in = v[3];
    endcase
  end

  assign sm_out = sm(sm_in);
  assign mask   = (rnd[0] ^ dec) ? MASK_33 : MASK_55;

  always_comb begin
    case (ki_i)
      2'd0:    sm_mul = sm_out;
      2'd1:    sm_mul = sm_out << 1;
      default: sm_mul = sm_out + (sm_out << 1);
    endcase
  end

  // key memory read address for the two whitening steps of a round
  always_comb begin
    if (state == ST_XOR_A) begin
      rd_base = dec ? 6'd52 - {rnd, 3'b000} : {rnd, 3'b000};
    end else begin
      rd_base = dec ? 6'd48 - {rnd, 3'b000} : {rnd, 3'b100};
    end
    rd_addr = AW'(rd_base + 6'(cnt));
  end

  assign pick_addr = ik_addr(et, es, cnt[1:0]);
  assign ex_x      = {pk[0][30:0], pk[0][31]} + pk[1];
  assign ex_z0     = {pk[2][30:0], pk[2][31]} - pk[3];
  assign ex_z      = {ex_z0[30:0], ex_z0[31]};

  // hold the key stores
  always_ff @(posedge clk) begin
    if (state == ST_KEY_INT && cnt == 3'd3) ik[ki_idx] <= sm_out;
    if (state == ST_KEY_EXP && cnt == 3'd4) ek_mem[n] <= ex_x ^ ex_z;
    rd_data <= ek_mem[rd_addr];
  end

  // block datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (din.valid) begin
          dec  <= din.kind;
          v[0] <= din.word_a;
          v[1] <= din.word_b;
          v[2] <= din.word_c;
          v[3] <= din.word_d;
        end
      end
      ST_KEY_INT: begin
        case (cnt[1:0])
          2'd0:    acc_x <= sm_out;
          2'd1:    acc_y <= sm_mul;
          2'd2:    acc_x <= acc_x + sm_out;
          default: acc_x <= acc_x;
        endcase
      end
      ST_KEY_EXP: begin
        if (cnt != 3'd4) pk[cnt[1:0]] <= ik[pick_addr];
      end
      ST_XOR_A, ST_XOR_B: begin
        if (cnt != 3'd0) v[cnt[1:0] - 2'd1] <= v[cnt[1:0] - 2'd1] ^ rd_data;
      end
      ST_SUB: v <= bitslice(v, dec);
      ST_ROUND: begin
        case (cnt[1:0])
          2'd0: tmp <= sm_out;
          2'd1: begin
            v[0] <= v[0] ^ (tmp & mask) ^ sm_out;
            v[1] <= v[1] ^ (sm_out & ~mask) ^ tmp;
          end
          2'd2: tmp <= sm_out;
          default: begin
            v[0] <= v[2] ^ (tmp & mask) ^ sm_out;
            v[1] <= v[3] ^ (sm_out & ~mask) ^ tmp;
            v[2] <= v[0];
            v[3] <= v[1];
          end
        endcase
      end
      default: v <= v;
    endcase
  end

  // hold the result for the sink
  always_ff @(posedge clk) begin
    if (out_load) res <= v;
  end

  assign dout.valid      = out_valid;
  assign dout.out_word_a = res[0];
  assign dout.out_word_b = res[1];
  assign dout.out_word_c = res[2];
  assign dout.out_word_d = res[3];

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    din.ready |-> state == ST_IDLE)
    else $error("input ready outside idle");

  a_key_clear: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && cfg.index < CFG_IDX_W'(CFG_REGS)) |=> !key_ready)
    else $error("key write did not drop key_ready");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside done state");

  a_round_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND || state == ST_KEY_INT) |-> cnt < 3'd4)
    else $error("step counter out of range");
`endif

endmodule
